FILE: hw/rtl/utsc_pkg.sv
// Package for the UTF-8 text screen: decoder state, result record and
// byte constants. Depends on nothing; every other file uses it.
package utsc_pkg;

    localparam int unsigned SIZE_WIDTH  = 32;
    localparam int unsigned TOTAL_WIDTH = 32;
    localparam int unsigned CP_WIDTH    = 21;

    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_TOO_LARGE = 2'd1;
    localparam logic [1:0] VERDICT_BINARY    = 2'd2;
    localparam logic [1:0] VERDICT_INVALID   = 2'd3;

    localparam logic [7:0] MARK_BYTE0 = 8'hEF;
    localparam logic [7:0] MARK_BYTE1 = 8'hBB;
    localparam logic [7:0] MARK_BYTE2 = 8'hBF;

    localparam logic [CP_WIDTH-1:0] CP_MIN_TWO       = 21'h80;
    localparam logic [CP_WIDTH-1:0] CP_MIN_THREE     = 21'h800;
    localparam logic [CP_WIDTH-1:0] CP_SURROGATE_LO  = 21'hD800;
    localparam logic [CP_WIDTH-1:0] CP_SURROGATE_HI  = 21'hDFFF;
    localparam logic [CP_WIDTH-1:0] CP_MIN_FOUR      = 21'h10000;
    localparam logic [CP_WIDTH-1:0] CP_MAX           = 21'h10FFFF;

    localparam logic [1:0] MARK_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]          bytes_pending;
        logic [1:0]          sequence_length;
        logic [CP_WIDTH-1:0] partial_code_point;
        logic                error_seen;
        logic                zero_byte_seen;
        logic [1:0]          mark_progress;
        logic                mark_broken;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]             verdict;
        logic                   bom_present;
        logic [TOTAL_WIDTH-1:0] total_bytes;
    } result_t;

endpackage

FILE: hw/rtl/utsc_ifs.sv
// Channel interfaces of the UTF-8 text screen: byte input, result output
// and the size limit write channel. Depends on utsc_pkg.
interface utsc_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utsc_result_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      verdict;
    logic                            bom_present;
    logic [utsc_pkg::TOTAL_WIDTH-1:0] total_bytes;

    modport source (output valid, output verdict, output bom_present, output total_bytes,
                    input ready);
    modport sink   (input valid, input verdict, input bom_present, input total_bytes,
                    output ready);
endinterface

interface utsc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [utsc_pkg::SIZE_WIDTH-1:0] size_limit;

    modport source (output valid, output size_limit, input ready);
    modport sink   (input valid, input size_limit, output ready);
endinterface

FILE: hw/rtl/utf8_text_screen.sv
// Top level of the UTF-8 text screen: input register, per-byte step logic
// and the result register. Depends on utsc_pkg, utsc_ifs and utsc_step.
//
//   channel   role     payload                                    transfer
//   text      sink     text_byte[7:0], end_of_text                valid & ready
//   result    source   verdict[1:0], bom_present, total_bytes     valid & ready
//   cfg       sink     size_limit[31:0]                           valid & ready
//
// One byte is taken every cycle unless a final byte waits on the result register.
// A byte is registered in the input register, then the decoder state is updated;
// a final byte loads the result register at that edge, from which its verdict
// is read. Reset clears the decoder state, the size limit and both valid flags.
// Only a final byte waits on a full result register; other bytes flow on.
module utf8_text_screen #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    utsc_text_if.sink            text,
    utsc_result_if.source        result,
    utsc_cfg_if.sink             cfg
);
    import utsc_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    scan_state_t            state_reg;
    scan_state_t            state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [SIZE_WIDTH-1:0]  size_limit_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    result_t                step_result;
    logic                   can_step;
    logic                   do_step;

    utsc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .cur_state   (state_reg),
        .cur_count   (count_reg),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .size_limit  (size_limit_reg),
        .next_state  (state_next),
        .next_count  (count_next),
        .result      (step_result)
    );

    // A final byte can only move on when the result register is free.
    assign can_step   = !in_last_reg || !out_valid_reg || result.ready;
    assign do_step    = in_valid_reg && can_step;
    assign text.ready = !in_valid_reg || can_step;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            state_reg      <= '0;
            count_reg      <= '0;
            size_limit_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (text.ready)
            begin
                in_valid_reg <= text.valid;
            end
            if (do_step)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
            end
            if (cfg.valid)
            begin
                size_limit_reg <= cfg.size_limit;
            end
            if (do_step && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            in_byte_reg <= text.text_byte;
            in_last_reg <= text.end_of_text;
        end
        if (do_step && in_last_reg)
        begin
            out_reg <= step_result;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.verdict     = out_reg.verdict;
    assign result.bom_present = out_reg.bom_present;
    assign result.total_bytes = out_reg.total_bytes;

endmodule

FILE: hw/rtl/utsc_step.sv
// Per-byte next-state logic of the UTF-8 text screen: decoder, mark
// tracking, byte counter and the verdict on the final byte. Uses utsc_pkg.
module utsc_step #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  utsc_pkg::scan_state_t                 cur_state,
    input  logic [COUNT_WIDTH-1:0]                cur_count,
    input  logic [7:0]                            text_byte,
    input  logic                                  end_of_text,
    input  logic [utsc_pkg::SIZE_WIDTH-1:0]       size_limit,
    output utsc_pkg::scan_state_t                 next_state,
    output logic [COUNT_WIDTH-1:0]                next_count,
    output utsc_pkg::result_t                     result
);
    import utsc_pkg::*;

    localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > SIZE_WIDTH) ? COUNT_WIDTH : SIZE_WIDTH;

    scan_state_t           st;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [7:0]            mark_expect;
    logic [CP_WIDTH-1:0]   cp;
    logic                  bad_cp;
    logic [CMP_WIDTH-1:0]  cnt_ext;
    logic                  over_limit;
    logic [1:0]            verdict;

    always_comb
    begin
        st  = cur_state;
        cnt = cur_count;

        // Leading byte-order mark: only the first three positions matter.
        case (cur_count[1:0])
            2'd0:    mark_expect = MARK_BYTE0;
            2'd1:    mark_expect = MARK_BYTE1;
            default: mark_expect = MARK_BYTE2;
        endcase
        if (!st.mark_broken && (cur_count < COUNT_WIDTH'(3)))
        begin
            if ((text_byte == mark_expect) && (st.mark_progress == cur_count[1:0]))
            begin
                st.mark_progress = cur_count[1:0] + 2'd1;
            end
            else
            begin
                st.mark_broken = 1'b1;
            end
        end

        if (cur_count != {COUNT_WIDTH{1'b1}})
        begin
            cnt = cur_count + COUNT_WIDTH'(1);
        end

        if (text_byte == 8'h00)
        begin
            st.zero_byte_seen = 1'b1;
        end

        cp     = {st.partial_code_point[CP_WIDTH-7:0], text_byte[5:0]};
        bad_cp = 1'b0;
        case (st.sequence_length)
            2'd1:    bad_cp = (cp < CP_MIN_TWO);
            2'd2:    bad_cp = (cp < CP_MIN_THREE) ||
                              ((cp >= CP_SURROGATE_LO) && (cp <= CP_SURROGATE_HI));
            default: bad_cp = (cp < CP_MIN_FOUR) || (cp > CP_MAX);
        endcase

        if (text_byte[7:6] == 2'b10)
        begin
            if (st.bytes_pending == 2'd0)
            begin
                st.error_seen = 1'b1;
            end
            else if (st.bytes_pending == 2'd1)
            begin
                // Last continuation byte closes the sequence.
                st.error_seen         = st.error_seen | bad_cp;
                st.bytes_pending      = 2'd0;
                st.sequence_length    = 2'd0;
                st.partial_code_point = '0;
            end
            else
            begin
                st.partial_code_point = cp;
                st.bytes_pending      = st.bytes_pending - 2'd1;
            end
        end
        else
        begin
            if (st.bytes_pending != 2'd0)
            begin
                st.error_seen         = 1'b1;
                st.bytes_pending      = 2'd0;
                st.sequence_length    = 2'd0;
                st.partial_code_point = '0;
            end
            case (text_byte) inside
                [8'h00:8'h7F]:
                begin
                end
                [8'hC0:8'hDF]:
                begin
                    st.partial_code_point = CP_WIDTH'(text_byte[4:0]);
                    st.bytes_pending      = 2'd1;
                    st.sequence_length    = 2'd1;
                end
                [8'hE0:8'hEF]:
                begin
                    st.partial_code_point = CP_WIDTH'(text_byte[3:0]);
                    st.bytes_pending      = 2'd2;
                    st.sequence_length    = 2'd2;
                end
                [8'hF0:8'hF7]:
                begin
                    st.partial_code_point = CP_WIDTH'(text_byte[2:0]);
                    st.bytes_pending      = 2'd3;
                    st.sequence_length    = 2'd3;
                end
                default:
                begin
                    st.error_seen = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        cnt_ext    = CMP_WIDTH'(cnt);
        over_limit = (size_limit != '0) && (cnt_ext > CMP_WIDTH'(size_limit));
        if (over_limit)
        begin
            verdict = VERDICT_TOO_LARGE;
        end
        else if (st.zero_byte_seen)
        begin
            verdict = VERDICT_BINARY;
        end
        else if (st.error_seen || (st.bytes_pending != 2'd0))
        begin
            verdict = VERDICT_INVALID;
        end
        else
        begin
            verdict = VERDICT_OK;
        end

        result.verdict     = verdict;
        result.bom_present = (verdict == VERDICT_OK) && !st.mark_broken &&
                             (st.mark_progress == MARK_DONE);
        result.total_bytes = (cnt_ext > CMP_WIDTH'({TOTAL_WIDTH{1'b1}})) ?
                             {TOTAL_WIDTH{1'b1}} : cnt_ext[TOTAL_WIDTH-1:0];

        // The final byte leaves a clean state for the next text.
        if (end_of_text)
        begin
            next_state = '0;
            next_count = '0;
        end
        else
        begin
            next_state = st;
            next_count = cnt;
        end
    end

endmodule
